### hw/rtl/pftr_pkg.sv
package pftr_pkg;

  localparam int PAGES     = 32;
  localparam int FRAGMENTS = 8;
  localparam int BUFFERS   = 16;

  // Index widths and counter widths (counters can hold the depth itself).
  localparam int PG_W  = $clog2(PAGES);
  localparam int PG_CW = $clog2(PAGES + 1);
  localparam int BF_W  = $clog2(BUFFERS);
  localparam int BF_CW = $clog2(BUFFERS + 1);

  localparam logic [7:0] FRAG_ALL = 8'((1 << FRAGMENTS) - 1);

  localparam logic [31:0] READ_TIMEOUT_RST = 32'd327680;

  localparam logic [2:0] OP_START  = 3'd0;
  localparam logic [2:0] OP_REPORT = 3'd1;
  localparam logic [2:0] OP_DATA   = 3'd2;
  localparam logic [2:0] OP_TAKE   = 3'd3;
  localparam logic [2:0] OP_STATUS = 3'd4;
  localparam logic [2:0] OP_BITMAP = 3'd5;

  typedef enum logic [2:0] {
    XS_NONE     = 3'd0,
    XS_STARTING = 3'd1,
    XS_META     = 3'd2,
    XS_DATA     = 3'd3,
    XS_DONE     = 3'd4,
    XS_FAILED   = 3'd5
  } xfer_t;

  typedef enum logic [2:0] {
    PG_UNKNOWN  = 3'd0,
    PG_UNUSED   = 3'd1,
    PG_RD_META  = 3'd2,
    PG_HAS_META = 3'd3,
    PG_RD_DATA  = 3'd4,
    PG_HAS_DATA = 3'd5,
    PG_ABORTED  = 3'd6
  } pg_state_t;

  typedef enum logic [1:0] {
    BF_UNUSED  = 2'd0,
    BF_READING = 2'd1,
    BF_READY   = 2'd2
  } buf_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RPT_SCAN,
    ST_DATA_EXEC,
    ST_QUERY_EXEC,
    ST_REQ_CHECK,
    ST_BUF_SCAN,
    ST_PG_SCAN,
    ST_TAKE_SCAN,
    ST_FINISH
  } ctl_state_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_START,
    CMD_FAIL,
    CMD_RPT_LATCH,
    CMD_RPT_PAGE,
    CMD_RPT_END,
    CMD_SEND,
    CMD_PG_SEL,
    CMD_DATA,
    CMD_QUERY,
    CMD_REQ_DONE,
    CMD_BUF_INIT,
    CMD_BUF_NEXT,
    CMD_BUF_FREE,
    CMD_PG_NEXT,
    CMD_PG_BIND,
    CMD_PG_FAIL,
    CMD_REQ_END,
    CMD_TAKE,
    CMD_TAKE_HIT,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       active;
    logic       starting;
    logic       meta;
    logic       data;
    logic       data_or_done;
    logic       low_battery;
    logic       serial_lt;
    logic       next_page_end;
    logic       pending_zero;
    logic       b_end;
    logic       b_unused;
    logic       b_ready;
    logic       pg_end;
    logic       pg_has_meta;
  } dp_status_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] now;
    logic        low_battery;
    logic [31:0] report_serial;
    logic [31:0] pages_in_use;
    logic [7:0]  page_index;
    logic [7:0]  fragment_index;
    logic [31:0] page_serial;
    logic [7:0]  unused_frag;
  } in_item_t;

  typedef struct packed {
    logic [2:0] transfer_status;
    logic       send_request;
    logic       ready_valid;
    logic [4:0] ready_page;
    logic [3:0] ready_buffer;
    logic [7:0] required_mask;
  } out_item_t;

endpackage

### hw/rtl/pftr_ctrl.sv
module pftr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_stall,
  input  pftr_pkg::dp_status_t sts,
  output pftr_pkg::cmd_t      cmd,
  output logic                in_stall,
  output logic                out_valid
);

  pftr_pkg::ctl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pftr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != pftr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = pftr_pkg::CMD_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      pftr_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd       = pftr_pkg::CMD_LOAD;
          state_nxt = pftr_pkg::ST_DISPATCH;
        end
      end
      pftr_pkg::ST_DISPATCH: begin
        state_nxt = pftr_pkg::ST_FINISH;
        priority if (sts.op == pftr_pkg::OP_START) begin
          cmd = pftr_pkg::CMD_START;
        end else if (sts.op == pftr_pkg::OP_REPORT) begin
          if (sts.active) begin
            priority if (sts.starting) begin
              if (sts.low_battery) begin
                cmd = pftr_pkg::CMD_FAIL;
              end else begin
                cmd       = pftr_pkg::CMD_RPT_LATCH;
                state_nxt = pftr_pkg::ST_RPT_SCAN;
              end
            end else if (sts.serial_lt) begin
              cmd = pftr_pkg::CMD_FAIL;
            end else if (sts.meta) begin
              cmd = pftr_pkg::CMD_SEND;
            end else if (sts.data) begin
              state_nxt = pftr_pkg::ST_REQ_CHECK;
            end else begin
              cmd = pftr_pkg::CMD_NONE;
            end
          end
        end else if (sts.op == pftr_pkg::OP_DATA) begin
          if (sts.active) begin
            cmd       = pftr_pkg::CMD_PG_SEL;
            state_nxt = pftr_pkg::ST_DATA_EXEC;
          end
        end else if (sts.op == pftr_pkg::OP_TAKE) begin
          cmd = pftr_pkg::CMD_TAKE;
          if (sts.data_or_done) state_nxt = pftr_pkg::ST_TAKE_SCAN;
        end else if (sts.op == pftr_pkg::OP_BITMAP) begin
          cmd       = pftr_pkg::CMD_PG_SEL;
          state_nxt = pftr_pkg::ST_QUERY_EXEC;
        end else begin
          cmd = pftr_pkg::CMD_NONE;
        end
      end
      pftr_pkg::ST_RPT_SCAN: begin
        if (sts.pg_end) begin
          cmd       = pftr_pkg::CMD_RPT_END;
          state_nxt = pftr_pkg::ST_FINISH;
        end else begin
          cmd = pftr_pkg::CMD_RPT_PAGE;
        end
      end
      pftr_pkg::ST_DATA_EXEC: begin
        cmd       = pftr_pkg::CMD_DATA;
        state_nxt = pftr_pkg::ST_FINISH;
      end
      pftr_pkg::ST_QUERY_EXEC: begin
        cmd       = pftr_pkg::CMD_QUERY;
        state_nxt = pftr_pkg::ST_FINISH;
      end
      pftr_pkg::ST_REQ_CHECK: begin
        if (sts.next_page_end) begin
          cmd       = sts.pending_zero ? pftr_pkg::CMD_REQ_DONE : pftr_pkg::CMD_SEND;
          state_nxt = pftr_pkg::ST_FINISH;
        end else begin
          cmd       = pftr_pkg::CMD_BUF_INIT;
          state_nxt = pftr_pkg::ST_BUF_SCAN;
        end
      end
      pftr_pkg::ST_BUF_SCAN: begin
        priority if (sts.b_end) begin
          cmd       = pftr_pkg::CMD_REQ_END;
          state_nxt = pftr_pkg::ST_FINISH;
        end else if (sts.b_unused) begin
          cmd       = pftr_pkg::CMD_BUF_FREE;
          state_nxt = pftr_pkg::ST_PG_SCAN;
        end else begin
          cmd = pftr_pkg::CMD_BUF_NEXT;
        end
      end
      pftr_pkg::ST_PG_SCAN: begin
        priority if (sts.pg_end) begin
          cmd       = pftr_pkg::CMD_PG_FAIL;
          state_nxt = pftr_pkg::ST_FINISH;
        end else if (sts.pg_has_meta) begin
          cmd       = pftr_pkg::CMD_PG_BIND;
          state_nxt = pftr_pkg::ST_BUF_SCAN;
        end else begin
          cmd = pftr_pkg::CMD_PG_NEXT;
        end
      end
      pftr_pkg::ST_TAKE_SCAN: begin
        priority if (sts.b_end) begin
          state_nxt = pftr_pkg::ST_FINISH;
        end else if (sts.b_ready) begin
          cmd       = pftr_pkg::CMD_TAKE_HIT;
          state_nxt = pftr_pkg::ST_FINISH;
        end else begin
          cmd = pftr_pkg::CMD_BUF_NEXT;
        end
      end
      pftr_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd           = pftr_pkg::CMD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = pftr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pftr_pkg::ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/pftr_datapath.sv
module pftr_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pftr_pkg::cmd_t       cmd,
  input  pftr_pkg::in_item_t   in_data,
  input  logic                 cfg_valid,
  input  logic [31:0]          cfg_data,
  output pftr_pkg::dp_status_t sts,
  output pftr_pkg::out_item_t  out_data
);

  // Architectural state.
  logic [31:0]           read_timeout_r;
  pftr_pkg::xfer_t       xfer_r;
  logic [31:0]           start_serial_r;
  pftr_pkg::pg_state_t   page_state_r   [pftr_pkg::PAGES];
  logic [7:0]            need_mask_r    [pftr_pkg::PAGES];
  logic [31:0]           header_serial_r[pftr_pkg::PAGES];
  logic [7:0]            header_unused_r[pftr_pkg::PAGES];
  logic [3:0]            page_to_buf_r  [pftr_pkg::PAGES];
  pftr_pkg::buf_state_t  buf_state_r    [pftr_pkg::BUFFERS];
  logic [4:0]            buf_to_page_r  [pftr_pkg::BUFFERS];
  logic [pftr_pkg::PG_CW-1:0] pending_r;
  logic [pftr_pkg::PG_CW-1:0] next_page_r;
  logic [31:0]           deadline_r;

  // Working registers for one transaction.
  pftr_pkg::in_item_t    item_r;
  logic [pftr_pkg::PG_CW-1:0] pg_idx_r;
  logic [pftr_pkg::BF_CW-1:0] b_idx_r;
  logic                  has_free_r;
  logic                  send_r;
  logic                  rvalid_r;
  logic [4:0]            rpage_r;
  logic [3:0]            rbuf_r;
  logic [7:0]            rmask_r;
  pftr_pkg::out_item_t   out_r;

  logic [pftr_pkg::PG_W-1:0] pg;
  logic [pftr_pkg::BF_W-1:0] bi;
  logic [pftr_pkg::BF_W-1:0] data_buf;
  logic [7:0]            frag_bit;
  logic [7:0]            need_left;
  logic [7:0]            bind_need;
  logic [pftr_pkg::PG_CW-1:0] pend_dec;
  logic [31:0]           tdiff;
  logic                  timed_out;
  logic                  bad_index;
  logic                  act;

  assign pg        = pg_idx_r[pftr_pkg::PG_W-1:0];
  assign bi        = b_idx_r[pftr_pkg::BF_W-1:0];
  assign data_buf  = page_to_buf_r[pg][pftr_pkg::BF_W-1:0];
  assign frag_bit  = 8'(8'd1 << item_r.fragment_index[2:0]);
  assign need_left = need_mask_r[pg] & ~frag_bit;
  assign bind_need = ~header_unused_r[pg] & pftr_pkg::FRAG_ALL;
  assign pend_dec  = (pending_r != '0) ? pending_r - 1'b1 : pending_r;
  assign tdiff     = item_r.now - deadline_r;
  assign timed_out = (tdiff != 32'd0) && !tdiff[31];
  assign bad_index = (item_r.page_index >= 8'(pftr_pkg::PAGES)) ||
                     (item_r.fragment_index >= 8'(pftr_pkg::FRAGMENTS));
  assign act       = (xfer_r == pftr_pkg::XS_STARTING) || (xfer_r == pftr_pkg::XS_META) ||
                     (xfer_r == pftr_pkg::XS_DATA);

  always_comb begin
    sts.op            = item_r.operation;
    sts.active        = act;
    sts.starting      = (xfer_r == pftr_pkg::XS_STARTING);
    sts.meta          = (xfer_r == pftr_pkg::XS_META);
    sts.data          = (xfer_r == pftr_pkg::XS_DATA);
    sts.data_or_done  = (xfer_r == pftr_pkg::XS_DATA) || (xfer_r == pftr_pkg::XS_DONE);
    sts.low_battery   = item_r.low_battery;
    sts.serial_lt     = item_r.report_serial < start_serial_r;
    sts.next_page_end = next_page_r >= pftr_pkg::PG_CW'(pftr_pkg::PAGES);
    sts.pending_zero  = (pending_r == '0);
    sts.b_end         = b_idx_r >= pftr_pkg::BF_CW'(pftr_pkg::BUFFERS);
    sts.b_unused      = (buf_state_r[bi] == pftr_pkg::BF_UNUSED);
    sts.b_ready       = (buf_state_r[bi] == pftr_pkg::BF_READY);
    sts.pg_end        = pg_idx_r >= pftr_pkg::PG_CW'(pftr_pkg::PAGES);
    sts.pg_has_meta   = (page_state_r[pg] == pftr_pkg::PG_HAS_META);
  end

  assign out_data = out_r;

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_timeout_r <= pftr_pkg::READ_TIMEOUT_RST;
      xfer_r         <= pftr_pkg::XS_NONE;
      start_serial_r <= '0;
      pending_r      <= '0;
      next_page_r    <= '0;
      deadline_r     <= '0;
      for (int i = 0; i < pftr_pkg::PAGES; i++) begin
        page_state_r[i] <= pftr_pkg::PG_UNKNOWN;
        need_mask_r[i]  <= '0;
      end
      for (int i = 0; i < pftr_pkg::BUFFERS; i++) begin
        buf_state_r[i] <= pftr_pkg::BF_UNUSED;
      end
    end else begin
      if (cfg_valid) read_timeout_r <= cfg_data;
      unique case (cmd)
        pftr_pkg::CMD_START: begin
          deadline_r <= item_r.now + read_timeout_r;
          xfer_r     <= pftr_pkg::XS_STARTING;
        end
        pftr_pkg::CMD_FAIL: xfer_r <= pftr_pkg::XS_FAILED;
        pftr_pkg::CMD_RPT_LATCH: begin
          start_serial_r <= item_r.report_serial;
          pending_r      <= '0;
        end
        pftr_pkg::CMD_RPT_PAGE: begin
          if (item_r.pages_in_use[pg]) begin
            need_mask_r[pg]  <= 8'd1;
            page_state_r[pg] <= pftr_pkg::PG_RD_META;
            pending_r        <= pending_r + 1'b1;
          end else begin
            need_mask_r[pg]  <= '0;
            page_state_r[pg] <= pftr_pkg::PG_UNUSED;
          end
        end
        pftr_pkg::CMD_RPT_END: begin
          xfer_r <= (pending_r != '0) ? pftr_pkg::XS_META : pftr_pkg::XS_FAILED;
        end
        pftr_pkg::CMD_DATA: begin
          if (bad_index) begin
            xfer_r <= pftr_pkg::XS_FAILED;
          end else if (xfer_r == pftr_pkg::XS_META) begin
            if (page_state_r[pg] == pftr_pkg::PG_RD_META) begin
              need_mask_r[pg]  <= '0;
              page_state_r[pg] <= pftr_pkg::PG_HAS_META;
              pending_r        <= pend_dec;
              if (pend_dec == '0) begin
                next_page_r <= '0;
                xfer_r      <= pftr_pkg::XS_DATA;
                for (int i = 0; i < pftr_pkg::BUFFERS; i++) begin
                  buf_state_r[i] <= pftr_pkg::BF_UNUSED;
                end
              end
            end
          end else if (xfer_r == pftr_pkg::XS_DATA) begin
            if (page_state_r[pg] == pftr_pkg::PG_RD_DATA &&
                (need_mask_r[pg] & frag_bit) != '0) begin
              if (header_serial_r[pg] != item_r.page_serial) begin
                need_mask_r[pg]       <= '0;
                pending_r             <= pend_dec;
                page_state_r[pg]      <= pftr_pkg::PG_ABORTED;
                buf_state_r[data_buf] <= pftr_pkg::BF_UNUSED;
              end else begin
                need_mask_r[pg] <= need_left;
                if (need_left == '0) begin
                  pending_r             <= pend_dec;
                  page_state_r[pg]      <= pftr_pkg::PG_HAS_DATA;
                  buf_state_r[data_buf] <= pftr_pkg::BF_READY;
                end
              end
            end
          end
        end
        pftr_pkg::CMD_REQ_DONE: xfer_r <= pftr_pkg::XS_DONE;
        pftr_pkg::CMD_PG_BIND: begin
          need_mask_r[pg] <= bind_need;
          next_page_r     <= pg_idx_r + 1'b1;
          if (bind_need != '0) begin
            pending_r        <= pending_r + 1'b1;
            page_state_r[pg] <= pftr_pkg::PG_RD_DATA;
            buf_state_r[bi]  <= pftr_pkg::BF_READING;
          end else begin
            page_state_r[pg] <= pftr_pkg::PG_HAS_DATA;
            buf_state_r[bi]  <= pftr_pkg::BF_READY;
          end
        end
        pftr_pkg::CMD_PG_FAIL: next_page_r <= pftr_pkg::PG_CW'(pftr_pkg::PAGES);
        pftr_pkg::CMD_REQ_END: begin
          if (!has_free_r && timed_out) xfer_r <= pftr_pkg::XS_FAILED;
        end
        pftr_pkg::CMD_TAKE: deadline_r <= item_r.now + read_timeout_r;
        pftr_pkg::CMD_TAKE_HIT: buf_state_r[bi] <= pftr_pkg::BF_UNUSED;
        default: ;
      endcase
    end
  end

  // Page headers, bindings and per-transaction working registers.
  always_ff @(posedge clk) begin
    unique case (cmd)
      pftr_pkg::CMD_LOAD: begin
        item_r   <= in_data;
        send_r   <= 1'b0;
        rvalid_r <= 1'b0;
        rpage_r  <= '0;
        rbuf_r   <= '0;
        rmask_r  <= '0;
      end
      pftr_pkg::CMD_RPT_LATCH: pg_idx_r <= '0;
      pftr_pkg::CMD_RPT_PAGE:  pg_idx_r <= pg_idx_r + 1'b1;
      pftr_pkg::CMD_RPT_END:   send_r   <= (pending_r != '0);
      pftr_pkg::CMD_SEND:      send_r   <= 1'b1;
      pftr_pkg::CMD_PG_SEL:    pg_idx_r <= pftr_pkg::PG_CW'(item_r.page_index[pftr_pkg::PG_W-1:0]);
      pftr_pkg::CMD_DATA: begin
        if (!bad_index && xfer_r == pftr_pkg::XS_META &&
            page_state_r[pg] == pftr_pkg::PG_RD_META) begin
          header_serial_r[pg] <= item_r.page_serial;
          header_unused_r[pg] <= item_r.unused_frag;
        end
      end
      pftr_pkg::CMD_QUERY: begin
        rmask_r <= (item_r.page_index < 8'(pftr_pkg::PAGES)) ? need_mask_r[pg] : 8'd0;
      end
      pftr_pkg::CMD_BUF_INIT: begin
        b_idx_r    <= '0;
        has_free_r <= 1'b0;
      end
      pftr_pkg::CMD_BUF_NEXT: b_idx_r <= b_idx_r + 1'b1;
      pftr_pkg::CMD_BUF_FREE: begin
        has_free_r <= 1'b1;
        pg_idx_r   <= next_page_r;
      end
      pftr_pkg::CMD_PG_NEXT: pg_idx_r <= pg_idx_r + 1'b1;
      pftr_pkg::CMD_PG_BIND: begin
        page_to_buf_r[pg] <= 4'(bi);
        buf_to_page_r[bi] <= 5'(pg);
        b_idx_r           <= b_idx_r + 1'b1;
      end
      pftr_pkg::CMD_PG_FAIL: send_r <= 1'b1;
      pftr_pkg::CMD_REQ_END: send_r <= !(!has_free_r && timed_out);
      pftr_pkg::CMD_TAKE:    b_idx_r <= '0;
      pftr_pkg::CMD_TAKE_HIT: begin
        rvalid_r <= 1'b1;
        rpage_r  <= buf_to_page_r[bi];
        rbuf_r   <= 4'(bi);
      end
      pftr_pkg::CMD_OUT: begin
        out_r.transfer_status <= xfer_r;
        out_r.send_request    <= send_r;
        out_r.ready_valid     <= rvalid_r;
        out_r.ready_page      <= rpage_r;
        out_r.ready_buffer    <= rbuf_r;
        out_r.required_mask   <= rmask_r;
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/paged_fragment_transfer_receiver_core.sv
// Receiver-side control of a paged, fragmented download.
// The input channel (in_valid, in_stall, in_data) carries one transaction per
// command: start, report, data packet, take page, status query or bitmap query.
// in_stall is high whenever a transaction is being worked on, so the block
// takes one transaction at a time; a new one may be accepted while the last
// result still waits on the output.
// The result channel (out_valid, out_stall, out_data) returns exactly one
// result per accepted transaction, held steady while out_stall is high; the
// finished result waits in the final state until the output register is free.
// Most commands go from dispatch straight to the final state; a data packet
// or a bitmap query first passes an execute state, and the block is idle again
// once the result is written. A report in the starting state, unless the
// battery is low, walks all pages, one per cycle. A report in the data state
// walks the buffers and, for each free one, the pages from the next-page
// pointer onwards, until the pages run out; the page pointer never moves back.
// Take page, in the data or done state, walks the buffers up to the first
// ready one. These page and buffer walks set the throughput.
// The cfg_ port writes the read timeout; cfg_ready is always high.
// Synchronous reset clears the transfer, page and buffer state and restores
// the default timeout; page headers and bindings are left undefined.
module paged_fragment_transfer_receiver_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pftr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pftr_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  pftr_pkg::cmd_t       cmd;
  pftr_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  // The sequencer decides one datapath command per cycle from the status.
  pftr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // All transfer, page and buffer state lives in the datapath.
  pftr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
